// ----- rtl/core/twcs_pkg.sv -----
// Shared types and constants for the tile window collision scan.
// Holds controller/datapath command and status structs and code names.
// No dependencies.
package twcs_pkg;

	// Default sizing, handed to the top level parameters
	localparam int DEF_MAX_COLS    = 256;
	localparam int DEF_MAX_ROWS    = 64;
	localparam int DEF_TILE_PIXELS = 32;
	localparam int DEF_MAX_BOX     = 16;

	// Field widths fixed by the interface
	localparam int CFG_DATA_W = 9;
	localparam int MAP_COLS_W = 9;
	localparam int MAP_ROWS_W = 7;
	localparam int HIT_X_W    = 13;
	localparam int HIT_Y_W    = 11;
	localparam int SX_W       = 10;
	localparam int SY_W       = 8;

	// Register values after reset
	localparam logic [MAP_COLS_W-1:0] MAP_COLS_RST = 9'd256;
	localparam logic [MAP_ROWS_W-1:0] MAP_ROWS_RST = 7'd64;

	// Register indexes
	localparam logic REG_MAP_COLS = 1'b0;
	localparam logic REG_MAP_ROWS = 1'b1;

	// Item function codes
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_QUERY = 1'b1;

	// Tile code that marks an empty cell (ASCII zero)
	localparam logic [7:0] EMPTY_CODE = 8'd48;

	typedef enum logic [1:0] {
		DIR_DOWN  = 2'd0,
		DIR_UP    = 2'd1,
		DIR_RIGHT = 2'd2,
		DIR_LEFT  = 2'd3
	} scan_dir_t;

	// Controller to datapath
	typedef struct packed {
		logic write_tile;  // store the accepted tile
		logic load_query;  // latch the accepted query, clear scan counters
		logic issue;       // read the current cell, advance counters
		logic capture;     // take the stage-two check into the result register
		logic out_load;    // move the result into the output register
	} twcs_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic empty;    // window has no cells
		logic last;     // current cell is the final one of the window
		logic hit_now;  // the cell read last cycle is on the map and solid
	} twcs_sts_t;

endpackage

// ----- rtl/core/twcs_dp.sv -----
// Datapath of the tile window collision scan: map registers, tile memory,
// window counters, cell read stage and result/output registers.
// Depends on twcs_pkg.
module twcs_dp
	import twcs_pkg::*;
#(
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int TILE_PIXELS = DEF_TILE_PIXELS,
	parameter int MAX_BOX     = DEF_MAX_BOX
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic [5:0]             tile_row,
	input  logic [7:0]             tile_col,
	input  logic [7:0]             tile_code,
	input  logic signed [SX_W-1:0] start_x,
	input  logic signed [SY_W-1:0] start_y,
	input  logic [4:0]             box_width,
	input  logic [4:0]             box_height,
	input  logic [1:0]             scan_dir,
	input  logic [3:0]             direction_tag,
	input  twcs_cmd_t              cmd,
	output twcs_sts_t              sts,
	output logic                   hit,
	output logic [HIT_X_W-1:0]     hit_x,
	output logic [HIT_Y_W-1:0]     hit_y,
	output logic [3:0]             tag_out
);

	localparam int DEPTH  = MAX_ROWS * MAX_COLS;
	localparam int ADDRW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNTW   = $clog2(MAX_BOX + 1);
	localparam int COLW   = $clog2(MAX_COLS + 1);
	localparam int ROWW   = $clog2(MAX_ROWS + 1);
	localparam int XW     = ((SX_W > CNTW) ? SX_W : CNTW) + 2;
	localparam int YW     = ((SY_W > CNTW) ? SY_W : CNTW) + 2;

	// Map size registers
	logic [MAP_COLS_W-1:0] map_cols_q;
	logic [MAP_ROWS_W-1:0] map_rows_q;

	// Latched query
	logic signed [SX_W-1:0] sx_q;
	logic signed [SY_W-1:0] sy_q;
	logic [CNTW-1:0]        bw_q;
	logic [CNTW-1:0]        bh_q;
	scan_dir_t              dir_q;
	logic [3:0]             tag_q;
	logic [COLW-1:0]        cols_q;
	logic [ROWW-1:0]        rows_q;

	// Window counters: a walks the outer loop, b the inner one
	logic [CNTW-1:0] a_q;
	logic [CNTW-1:0] b_q;

	// Cell read stage
	logic           valid_s1;
	logic [XW-1:0]  x_s1;
	logic [YW-1:0]  y_s1;
	logic [7:0]     rd_s1;

	// Result and output registers
	logic               res_hit_q;
	logic [HIT_X_W-1:0] res_x_q;
	logic [HIT_Y_W-1:0] res_y_q;
	logic [3:0]         res_tag_q;
	logic               hit_q;
	logic [HIT_X_W-1:0] hit_x_q;
	logic [HIT_Y_W-1:0] hit_y_q;
	logic [3:0]         tag_out_q;

	logic [7:0] mem [DEPTH];

	logic [CNTW-1:0]      outer_n;
	logic [CNTW-1:0]      inner_n;
	logic [CNTW-1:0]      outer_m1;
	logic [CNTW-1:0]      inner_m1;
	logic signed [XW-1:0] a_sx;
	logic signed [XW-1:0] b_sx;
	logic signed [YW-1:0] a_sy;
	logic signed [YW-1:0] b_sy;
	logic signed [XW-1:0] cell_x;
	logic signed [YW-1:0] cell_y;
	logic                 in_map;
	logic [ADDRW-1:0]     rd_addr;
	logic [ADDRW-1:0]     wr_addr;
	logic                 wr_ok;
	logic [CNTW-1:0]      bw_d;
	logic [CNTW-1:0]      bh_d;
	logic [COLW-1:0]      cols_d;
	logic [ROWW-1:0]      rows_d;
	logic                 hit_now;

	// Clamp window and map sizes at query load
	assign bw_d   = (32'(box_width) > MAX_BOX) ? CNTW'(MAX_BOX) : CNTW'(box_width);
	assign bh_d   = (32'(box_height) > MAX_BOX) ? CNTW'(MAX_BOX) : CNTW'(box_height);
	assign cols_d = (32'(map_cols_q) > MAX_COLS) ? COLW'(MAX_COLS) : COLW'(map_cols_q);
	assign rows_d = (32'(map_rows_q) > MAX_ROWS) ? ROWW'(MAX_ROWS) : ROWW'(map_rows_q);

	assign outer_n  = (dir_q == DIR_DOWN || dir_q == DIR_UP) ? bh_q : bw_q;
	assign inner_n  = (dir_q == DIR_DOWN || dir_q == DIR_UP) ? bw_q : bh_q;
	assign outer_m1 = outer_n - CNTW'(1);
	assign inner_m1 = inner_n - CNTW'(1);

	assign a_sx = signed'({{(XW-CNTW){1'b0}}, a_q});
	assign b_sx = signed'({{(XW-CNTW){1'b0}}, b_q});
	assign a_sy = signed'({{(YW-CNTW){1'b0}}, a_q});
	assign b_sy = signed'({{(YW-CNTW){1'b0}}, b_q});

	always_comb begin
		unique case (dir_q)
			DIR_DOWN: begin
				cell_x = XW'(sx_q) + b_sx;
				cell_y = YW'(sy_q) + a_sy;
			end
			DIR_UP: begin
				cell_x = XW'(sx_q) + b_sx;
				cell_y = YW'(sy_q) - a_sy;
			end
			DIR_RIGHT: begin
				cell_x = XW'(sx_q) + a_sx;
				cell_y = YW'(sy_q) + b_sy;
			end
			DIR_LEFT: begin
				cell_x = XW'(sx_q) - a_sx;
				cell_y = YW'(sy_q) + b_sy;
			end
			default: begin
				cell_x = XW'(sx_q);
				cell_y = YW'(sy_q);
			end
		endcase
	end

	assign in_map = !cell_x[XW-1] && !cell_y[YW-1]
		&& (32'(unsigned'(cell_x)) < 32'(cols_q))
		&& (32'(unsigned'(cell_y)) < 32'(rows_q));

	assign rd_addr = ADDRW'(32'(unsigned'(cell_y)) * MAX_COLS + 32'(unsigned'(cell_x)));
	assign wr_addr = ADDRW'(32'(tile_row) * MAX_COLS + 32'(tile_col));
	assign wr_ok   = (32'(tile_row) < MAX_ROWS) && (32'(tile_col) < MAX_COLS);

	assign hit_now = valid_s1 && (rd_s1 != EMPTY_CODE);

	assign sts.empty   = (bw_q == '0) || (bh_q == '0);
	assign sts.last    = (a_q == outer_m1) && (b_q == inner_m1);
	assign sts.hit_now = hit_now;

	// Tile memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write_tile && wr_ok) begin
			mem[wr_addr] <= tile_code;
		end
		if (cmd.issue) begin
			rd_s1 <= mem[rd_addr];
		end
	end

	// Control: map registers, counters, read-stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q <= MAP_COLS_RST;
			map_rows_q <= MAP_ROWS_RST;
			a_q        <= '0;
			b_q        <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MAP_COLS: map_cols_q <= cfg_data[MAP_COLS_W-1:0];
					REG_MAP_ROWS: map_rows_q <= cfg_data[MAP_ROWS_W-1:0];
					default: ;
				endcase
			end
			valid_s1 <= cmd.issue && in_map;
			if (cmd.load_query) begin
				a_q <= '0;
				b_q <= '0;
			end else if (cmd.issue) begin
				// advance inner, wrap into outer
				if (b_q == inner_m1) begin
					b_q <= '0;
					a_q <= a_q + CNTW'(1);
				end else begin
					b_q <= b_q + CNTW'(1);
				end
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_query) begin
			sx_q   <= start_x;
			sy_q   <= start_y;
			bw_q   <= bw_d;
			bh_q   <= bh_d;
			dir_q  <= scan_dir_t'(scan_dir);
			tag_q  <= direction_tag;
			cols_q <= cols_d;
			rows_q <= rows_d;
		end
		if (cmd.issue) begin
			x_s1 <= unsigned'(cell_x);
			y_s1 <= unsigned'(cell_y);
		end
		if (cmd.capture) begin
			res_hit_q <= hit_now;
			res_x_q   <= hit_now ? HIT_X_W'(x_s1 * TILE_PIXELS) : '0;
			res_y_q   <= hit_now ? HIT_Y_W'(y_s1 * TILE_PIXELS) : '0;
			res_tag_q <= hit_now ? tag_q : '0;
		end
		if (cmd.out_load) begin
			hit_q     <= res_hit_q;
			hit_x_q   <= res_x_q;
			hit_y_q   <= res_y_q;
			tag_out_q <= res_tag_q;
		end
	end

	assign hit     = hit_q;
	assign hit_x   = hit_x_q;
	assign hit_y   = hit_y_q;
	assign tag_out = tag_out_q;

endmodule

// ----- rtl/core/twcs_ctrl.sv -----
// Controller of the tile window collision scan: handshakes and scan sequencing.
// Drives datapath commands from its status. Depends on twcs_pkg.
module twcs_ctrl
	import twcs_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  logic      func,
	output logic      out_valid,
	input  logic      out_ready,
	input  twcs_sts_t sts,
	output twcs_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FLUSH,
		ST_DONE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.write_tile = accept && (func == FUNC_WRITE);
				cmd.load_query = accept && (func == FUNC_QUERY);
				// no read in flight, so this takes a miss
				cmd.capture    = accept && (func == FUNC_WRITE);
			end
			ST_SCAN: begin
				if (sts.hit_now || sts.empty) begin
					cmd.capture = 1'b1;
				end else begin
					cmd.issue = 1'b1;
				end
			end
			ST_FLUSH: begin
				cmd.capture = 1'b1;
			end
			ST_DONE: begin
				cmd.out_load = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (func == FUNC_QUERY) ? ST_SCAN : ST_DONE;
					end
				end
				ST_SCAN: begin
					if (sts.hit_now || sts.empty) begin
						state_q <= ST_DONE;
					end else if (sts.last) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (cmd.out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- rtl/core/tile_window_collision_scan.sv -----
// Tile window collision scan. A tile write gives its transaction from the output register
// once that register is free; a query first scans its window up to the first hit or the last
// cell (no cells are read for an empty window) and then gives its transaction the same way.
// Throughput: one item at a time, one tile memory read per cycle, up to 256 reads.
// Reset (arst_n, async low) idles the controller, empties the output and restores
// map_cols = 256, map_rows = 64; tile memory contents are undefined until written.
module tile_window_collision_scan
	import twcs_pkg::*;
#(
	parameter int MAX_COLS    = DEF_MAX_COLS,
	parameter int MAX_ROWS    = DEF_MAX_ROWS,
	parameter int TILE_PIXELS = DEF_TILE_PIXELS,
	parameter int MAX_BOX     = DEF_MAX_BOX
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration writes
	input  logic                   cfg_we,
	input  logic                   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input transactions
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   func,
	input  logic [5:0]             tile_row,
	input  logic [7:0]             tile_col,
	input  logic [7:0]             tile_code,
	input  logic signed [SX_W-1:0] start_x,
	input  logic signed [SY_W-1:0] start_y,
	input  logic [4:0]             box_width,
	input  logic [4:0]             box_height,
	input  logic [1:0]             scan_dir,
	input  logic [3:0]             direction_tag,
	// result transactions
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   hit,
	output logic [HIT_X_W-1:0]     hit_x,
	output logic [HIT_Y_W-1:0]     hit_y,
	output logic [3:0]             tag_out
);

	// The controller only sequences; every stored value lives in the datapath.
	// A query walks the window one cell per cycle: the cell's address goes to
	// the tile memory, and in the next cycle the read data is checked. The first
	// solid cell on the map stops the walk and its position is scaled to pixels.
	// The output register frees the scan from the consumer: a new transaction
	// is accepted while the previous result still waits to be taken.
	twcs_cmd_t cmd;
	twcs_sts_t sts;

	twcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.func      (func),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	twcs_dp #(
		.MAX_COLS    (MAX_COLS),
		.MAX_ROWS    (MAX_ROWS),
		.TILE_PIXELS (TILE_PIXELS),
		.MAX_BOX     (MAX_BOX)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.tile_row      (tile_row),
		.tile_col      (tile_col),
		.tile_code     (tile_code),
		.start_x       (start_x),
		.start_y       (start_y),
		.box_width     (box_width),
		.box_height    (box_height),
		.scan_dir      (scan_dir),
		.direction_tag (direction_tag),
		.cmd           (cmd),
		.sts           (sts),
		.hit           (hit),
		.hit_x         (hit_x),
		.hit_y         (hit_y),
		.tag_out       (tag_out)
	);

	// A fresh transaction never sees a stale read from an earlier scan
	a_no_stale_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !sts.hit_now)
		else $error("stale read check after acceptance");

	// A cell read is always followed by its check before input opens again
	a_issue_holds_input: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |=> !in_ready)
		else $error("input opened with a cell read in flight");

	// Once a result is captured, no further cells are read for that transaction
	a_capture_stops_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |=> !cmd.issue)
		else $error("cell read after result capture");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// Testbench for tile_window_collision_scan: directed rows, then random map loads and window
// queries checked against a scan predictor. Depends on twcs_pkg and the scan RTL only.
module testbench;
	import twcs_pkg::*;

	localparam int STORE_COLS      = DEF_MAX_COLS;
	localparam int STORE_ROWS      = DEF_MAX_ROWS;
	localparam int PIXELS_PER_TILE = DEF_TILE_PIXELS;
	localparam int BOX_LIMIT       = DEF_MAX_BOX;
	localparam int RESET_CYCLES    = 12;
	localparam int CFG_SETTLE      = 4;
	localparam int DRAIN_CYCLES    = 20;
	localparam int RUN_LIMIT       = 2_000_000;
	localparam int NUM_PHASES      = 7;

	typedef enum int {
		SCAN_NONE,
		SCAN_SOLID,
		SCAN_UNWRITTEN
	} scan_outcome_t;

	typedef struct {
		logic                   func;
		logic [5:0]             tile_row;
		logic [7:0]             tile_col;
		logic [7:0]             tile_code;
		logic signed [SX_W-1:0] start_x;
		logic signed [SY_W-1:0] start_y;
		logic [4:0]             box_width;
		logic [4:0]             box_height;
		scan_dir_t              scan_dir;
		logic [3:0]             direction_tag;
	} tile_item_t;

	typedef struct {
		logic               hit;
		logic [HIT_X_W-1:0] hit_x;
		logic [HIT_Y_W-1:0] hit_y;
		logic [3:0]         tag_out;
	} scan_result_t;

	typedef struct {
		tile_item_t   item;
		scan_result_t want;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic func;
	logic [5:0] tile_row;
	logic [7:0] tile_col;
	logic [7:0] tile_code;
	logic signed [SX_W-1:0] start_x;
	logic signed [SY_W-1:0] start_y;
	logic [4:0] box_width;
	logic [4:0] box_height;
	logic [1:0] scan_dir;
	logic [3:0] direction_tag;
	logic out_valid;
	logic out_ready;
	logic hit;
	logic [HIT_X_W-1:0] hit_x;
	logic [HIT_Y_W-1:0] hit_y;
	logic [3:0] tag_out;

	// Shadow of the block: tile store, which tiles were loaded, and the map size registers
	logic [7:0] tile_store [STORE_ROWS*STORE_COLS];
	bit tile_written [STORE_ROWS*STORE_COLS];
	logic [MAP_COLS_W-1:0] cols_setting;
	logic [MAP_ROWS_W-1:0] rows_setting;

	scan_result_t pending_results [$];
	scan_result_t oldest_result;
	directed_row_t directed_rows [$];

	int send_idle_pct;
	int recv_idle_pct;
	int fail_count = 0;
	int cycle_count = 0;
	int items_sent = 0;
	int queries_sent = 0;
	int hits_seen = 0;

	// Map size per random phase: storage overflow, empty maps, a single tile, odd sizes.
	// The rows value carries high bits that the 7-bit register must drop.
	int phase_cols [NUM_PHASES] = '{511, 0, 256, 1, 37, 0, 256};
	int phase_rows [NUM_PHASES] = '{383, 64, 0, 1, 20, 0, 448};
	int phase_items [NUM_PHASES] = '{200, 40, 40, 150, 200, 200, 220};
	int phase_pressure [NUM_PHASES] = '{0, 0, 0, 1, 1, 2, 2};

	tile_window_collision_scan #(
		.MAX_COLS   (STORE_COLS),
		.MAX_ROWS   (STORE_ROWS),
		.TILE_PIXELS(PIXELS_PER_TILE),
		.MAX_BOX    (BOX_LIMIT)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.tile_row     (tile_row),
		.tile_col     (tile_col),
		.tile_code    (tile_code),
		.start_x      (start_x),
		.start_y      (start_y),
		.box_width    (box_width),
		.box_height   (box_height),
		.scan_dir     (scan_dir),
		.direction_tag(direction_tag),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.hit          (hit),
		.hit_x        (hit_x),
		.hit_y        (hit_y),
		.tag_out      (tag_out)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Effective map size: register values beyond storage act as the storage size
	function automatic int cols_in_use();
		return (cols_setting > STORE_COLS) ? STORE_COLS : int'(cols_setting);
	endfunction

	function automatic int rows_in_use();
		return (rows_setting > STORE_ROWS) ? STORE_ROWS : int'(rows_setting);
	endfunction

	// Walk the window in scan order, skipping off-map cells. Stop at the first solid tile,
	// or, when asked, at the first on-map tile that was never loaded. An unloaded tile
	// reads as code zero, which counts as solid.
	function automatic scan_outcome_t scan_window(input tile_item_t q, input bit stop_on_unwritten,
			output int cx, output int cy);
		int sx, sy, bw, bh, outer_n, inner_n, idx;
		sx = int'(q.start_x);
		sy = int'(q.start_y);
		bw = (q.box_width > BOX_LIMIT) ? BOX_LIMIT : int'(q.box_width);
		bh = (q.box_height > BOX_LIMIT) ? BOX_LIMIT : int'(q.box_height);
		outer_n = (q.scan_dir == DIR_DOWN || q.scan_dir == DIR_UP) ? bh : bw;
		inner_n = (q.scan_dir == DIR_DOWN || q.scan_dir == DIR_UP) ? bw : bh;
		cx = 0;
		cy = 0;
		for (int a = 0; a < outer_n; a++) begin
			for (int b = 0; b < inner_n; b++) begin
				case (q.scan_dir)
					DIR_DOWN: begin
						cx = sx + b;
						cy = sy + a;
					end
					DIR_UP: begin
						cx = sx + b;
						cy = sy - a;
					end
					DIR_RIGHT: begin
						cx = sx + a;
						cy = sy + b;
					end
					default: begin
						cx = sx - a;
						cy = sy + b;
					end
				endcase
				if (cx >= 0 && cy >= 0 && cx < cols_in_use() && cy < rows_in_use()) begin
					idx = cy * STORE_COLS + cx;
					if (stop_on_unwritten && !tile_written[idx])
						return SCAN_UNWRITTEN;
					if (tile_store[idx] != EMPTY_CODE)
						return SCAN_SOLID;
				end
			end
		end
		return SCAN_NONE;
	endfunction

	// Advance the shadow by one accepted transaction and return the result it must give
	function automatic scan_result_t apply_item(input tile_item_t it);
		scan_result_t res;
		int cx, cy, idx;
		res.hit = 1'b0;
		res.hit_x = '0;
		res.hit_y = '0;
		res.tag_out = '0;
		if (it.func == FUNC_WRITE) begin
			if (it.tile_row < STORE_ROWS && it.tile_col < STORE_COLS) begin
				idx = int'(it.tile_row) * STORE_COLS + int'(it.tile_col);
				tile_store[idx] = it.tile_code;
				tile_written[idx] = 1'b1;
			end
		end else if (scan_window(it, 1'b0, cx, cy) == SCAN_SOLID) begin
			res.hit = 1'b1;
			res.hit_x = HIT_X_W'(cx * PIXELS_PER_TILE);
			res.hit_y = HIT_Y_W'(cy * PIXELS_PER_TILE);
			res.tag_out = it.direction_tag;
		end
		return res;
	endfunction

	function automatic tile_item_t random_fields();
		tile_item_t it;
		it.func = 1'($urandom_range(0, 1));
		it.tile_row = 6'($urandom_range(0, 63));
		it.tile_col = 8'($urandom_range(0, 255));
		it.tile_code = 8'($urandom_range(0, 255));
		it.start_x = SX_W'($urandom_range(0, 1023));
		it.start_y = SY_W'($urandom_range(0, 255));
		it.box_width = 5'($urandom_range(0, 31));
		it.box_height = 5'($urandom_range(0, 31));
		it.scan_dir = scan_dir_t'($urandom_range(0, 3));
		it.direction_tag = 4'($urandom_range(0, 15));
		return it;
	endfunction

	// Mostly empty tiles, so that scans run deep before they find something
	function automatic logic [7:0] random_code();
		return ($urandom_range(0, 99) < 90) ? EMPTY_CODE : 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [4:0] random_box_size();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0)
			return 5'd0;
		if (pick == 1)
			return 5'($urandom_range(BOX_LIMIT + 1, 31));
		return 5'($urandom_range(1, BOX_LIMIT));
	endfunction

	function automatic tile_item_t random_query();
		tile_item_t q;
		q = random_fields();
		q.func = FUNC_QUERY;
		case ($urandom_range(0, 9))
			0: ; // keep the fully random start, mostly far off the map
			1, 2: begin
				// straddle the far corner of the configured map
				q.start_x = SX_W'(cols_in_use() - 10 + $urandom_range(0, 16));
				q.start_y = SY_W'(rows_in_use() - 10 + $urandom_range(0, 16));
			end
			default: begin
				q.start_x = SX_W'($urandom_range(0, 24) - 6);
				q.start_y = SY_W'($urandom_range(0, 16) - 6);
			end
		endcase
		q.box_width = random_box_size();
		q.box_height = random_box_size();
		return q;
	endfunction

	function automatic tile_item_t make_write(input int row, input int col, input int code);
		tile_item_t it;
		it = '{default: '0, scan_dir: DIR_DOWN};
		it.func = FUNC_WRITE;
		it.tile_row = 6'(row);
		it.tile_col = 8'(col);
		it.tile_code = 8'(code);
		return it;
	endfunction

	function automatic tile_item_t make_query(input int sx, input int sy, input int w, input int h,
			input scan_dir_t dir, input int tag);
		tile_item_t it;
		it = '{default: '0, scan_dir: DIR_DOWN};
		it.func = FUNC_QUERY;
		it.start_x = SX_W'(sx);
		it.start_y = SY_W'(sy);
		it.box_width = 5'(w);
		it.box_height = 5'(h);
		it.scan_dir = dir;
		it.direction_tag = 4'(tag);
		return it;
	endfunction

	// Queue one directed row with its result typed in: pixel position given directly
	function automatic void add_directed(input tile_item_t it, input bit want_hit,
			input int want_x, input int want_y);
		directed_row_t r;
		r.item = it;
		r.want.hit = want_hit;
		r.want.hit_x = HIT_X_W'(want_x);
		r.want.hit_y = HIT_Y_W'(want_y);
		r.want.tag_out = want_hit ? it.direction_tag : 4'd0;
		directed_rows.push_back(r);
	endfunction

	// Idle pattern: 0 sender light / receiver heavy, 1 the reverse, 2 no idling
	function automatic void set_pressure(input int mode);
		case (mode)
			0: begin
				send_idle_pct = 10;
				recv_idle_pct = 50;
			end
			1: begin
				send_idle_pct = 50;
				recv_idle_pct = 10;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Present one transaction from a falling edge and hold it until accepted. Predict the
	// result at the accepting edge; a typed-in result overrides the prediction.
	task automatic send_item(input tile_item_t it, input bit use_typed, input scan_result_t typed);
		scan_result_t predicted;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		func <= it.func;
		tile_row <= it.tile_row;
		tile_col <= it.tile_col;
		tile_code <= it.tile_code;
		start_x <= it.start_x;
		start_y <= it.start_y;
		box_width <= it.box_width;
		box_height <= it.box_height;
		scan_dir <= it.scan_dir;
		direction_tag <= it.direction_tag;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_item(it);
		pending_results.push_back(use_typed ? typed : predicted);
		items_sent++;
		if (it.func == FUNC_QUERY)
			queries_sent++;
		@(negedge clk);
	endtask

	// Write both map size registers once the block has drained
	task automatic write_map_size(input int cols, input int rows);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (CFG_SETTLE) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_MAP_COLS;
		cfg_data <= CFG_DATA_W'(cols);
		@(negedge clk);
		cfg_index <= REG_MAP_ROWS;
		cfg_data <= CFG_DATA_W'(rows);
		@(negedge clk);
		cfg_we <= 1'b0;
		cols_setting = MAP_COLS_W'(cols);
		rows_setting = MAP_ROWS_W'(rows);
		@(negedge clk);
	endtask

	// Receiver side: drop ready at random according to the current pattern
	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// Check every result transaction against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result transaction with nothing expected: hit=%0d hit_x=%0d hit_y=%0d",
					hit, hit_x, hit_y);
				fail_count++;
			end else begin
				oldest_result = pending_results.pop_front();
				check_field("hit", 32'(oldest_result.hit), 32'(hit));
				check_field("hit_x", 32'(oldest_result.hit_x), 32'(hit_x));
				check_field("hit_y", 32'(oldest_result.hit_y), 32'(hit_y));
				check_field("tag_out", 32'(oldest_result.tag_out), 32'(tag_out));
				if (hit === 1'b1)
					hits_seen++;
			end
		end
	end

	// Watchdog: end a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= RUN_LIMIT) begin
			$display("watchdog expired after %0d cycles, %0d results outstanding",
				cycle_count, pending_results.size());
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		tile_item_t it;
		scan_result_t no_typed;
		int cx, cy, phase_count;

		// Drive every input to a known value before reset releases
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_MAP_COLS;
		cfg_data = '0;
		in_valid = 1'b0;
		func = FUNC_WRITE;
		tile_row = '0;
		tile_col = '0;
		tile_code = '0;
		start_x = '0;
		start_y = '0;
		box_width = '0;
		box_height = '0;
		scan_dir = DIR_DOWN;
		direction_tag = '0;
		out_ready = 1'b0;
		no_typed = '{default: '0};
		for (int i = 0; i < STORE_ROWS * STORE_COLS; i++) begin
			tile_store[i] = 8'd0;
			tile_written[i] = 1'b0;
		end
		cols_setting = MAP_COLS_RST;
		rows_setting = MAP_ROWS_RST;
		set_pressure(0);

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows at the reset map size (256 x 64). Load a small patch at the origin
		// and at the far corner, then scan it in every order, with empty and oversized
		// windows, windows partly and wholly off the map, and the largest pixel position.
		add_directed(make_write(0, 0, 65), 1'b0, 0, 0);
		add_directed(make_write(0, 1, 48), 1'b0, 0, 0);
		add_directed(make_write(1, 0, 48), 1'b0, 0, 0);
		add_directed(make_write(1, 1, 0), 1'b0, 0, 0);
		add_directed(make_write(63, 255, 255), 1'b0, 0, 0);
		add_directed(make_write(63, 254, 48), 1'b0, 0, 0);
		add_directed(make_write(62, 255, 48), 1'b0, 0, 0);
		add_directed(make_query(0, 0, 1, 1, DIR_DOWN, 15), 1'b1, 0, 0);
		add_directed(make_query(1, 0, 1, 2, DIR_DOWN, 3), 1'b1, 32, 32);
		add_directed(make_query(0, 1, 1, 2, DIR_UP, 5), 1'b1, 0, 0);
		add_directed(make_query(0, 1, 2, 1, DIR_RIGHT, 6), 1'b1, 32, 32);
		add_directed(make_query(1, 0, 2, 1, DIR_LEFT, 7), 1'b1, 0, 0);
		add_directed(make_query(0, 0, 0, 16, DIR_DOWN, 9), 1'b0, 0, 0);
		add_directed(make_query(0, 0, 16, 0, DIR_RIGHT, 9), 1'b0, 0, 0);
		add_directed(make_query(-512, -128, 16, 16, DIR_DOWN, 1), 1'b0, 0, 0);
		add_directed(make_query(255, 63, 31, 31, DIR_DOWN, 10), 1'b1, 8160, 2016);
		add_directed(make_query(-3, -2, 4, 3, DIR_DOWN, 2), 1'b1, 0, 0);
		add_directed(make_query(511, 127, 16, 16, DIR_LEFT, 4), 1'b0, 0, 0);
		add_directed(make_query(256, 62, 2, 2, DIR_LEFT, 11), 1'b1, 8160, 2016);
		add_directed(make_query(1, 0, 1, 1, DIR_DOWN, 12), 1'b0, 0, 0);
		foreach (directed_rows[i])
			send_item(directed_rows[i].item, 1'b1, directed_rows[i].want);

		// Random phases, one map size each. Most transactions are queries; before each one,
		// load every tile it would read that was never loaded, with random mostly empty
		// codes. The rest are stray tile writes anywhere in storage.
		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == 5) begin
				phase_cols[p] = $urandom_range(1, STORE_COLS);
				phase_rows[p] = $urandom_range(1, STORE_ROWS);
			end
			write_map_size(phase_cols[p], phase_rows[p]);
			set_pressure(phase_pressure[p]);
			phase_count = 0;
			while (phase_count < phase_items[p]) begin
				if ($urandom_range(0, 99) < 20) begin
					it = random_fields();
					it.func = FUNC_WRITE;
					it.tile_code = random_code();
					send_item(it, 1'b0, no_typed);
					phase_count++;
				end else begin
					it = random_query();
					while (scan_window(it, 1'b1, cx, cy) == SCAN_UNWRITTEN) begin
						send_item(make_write(cy, cx, int'(random_code())), 1'b0, no_typed);
						phase_count++;
					end
					send_item(it, 1'b0, no_typed);
					phase_count++;
				end
			end
		end

		// Drain: wait for the last results, then hold a little longer for strays
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d transactions (%0d window queries, %0d hits) over %0d map sizes,",
			items_sent, queries_sent, hits_seen, NUM_PHASES + 1);
		$display("all four scan orders, empty, oversized and off-map windows, three idle patterns");
		if (fail_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/core/twcs_pkg.sv
rtl/core/twcs_dp.sv
rtl/core/twcs_ctrl.sv
rtl/core/tile_window_collision_scan.sv
tb/sv/testbench.sv
